/* hdl/lesf_pkg.sv */
package lesf_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 4096;

    localparam int BYTE_W = 8;
    localparam int SIDE_W = 11;
    localparam int CROW_W = 12;
    localparam int CCOL_W = 10;

    localparam logic [BYTE_W-1:0] OBSTACLE_RESET = 8'd111;

    // control that goes with a cell into the best-square stage
    typedef struct packed {
        logic valid;
        logic take;
        logic map_end;
    } t_cell_ctl;

endpackage

/* hdl/largest_empty_square_finder.sv */
// largest empty square finder: map bytes stream in row-major order, one cell
// per beat, with row_end and map_end marks. a cell equal to the obstacle byte
// (configuration write, reset 111) is blocked. at each map_end beat one result
// beat gives the side of the largest all-empty square and its top-left corner;
// ties go to the corner first in row-major order, side 0 with corner 0,0 if no
// cell is empty. one cell is accepted every cycle unless input is held back;
// a map result passes through stage 1, stage 2 and the output register. the
// rate is set by the line buffer, a MAX_COLS-deep memory read and registered
// at the accept stage ahead of the min-of-three update in stage 1, which is
// written back with forwarding for one-cell rows. input is held back only
// when a map result cannot move into an output register that still holds an
// untaken result. cells beyond MAX_COLS or MAX_ROWS are ignored but their
// marks still act. there is no clearing pass after reset: the length of the
// previous row gates every read of the line buffer.
module largest_empty_square_finder #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lesf_pkg::BYTE_W-1:0] i_cfg_data,
    // cell channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lesf_pkg::BYTE_W-1:0] i_cell_byte,
    input  logic                        i_row_end,
    input  logic                        i_map_end,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lesf_pkg::SIDE_W-1:0] o_largest_side,
    output logic [lesf_pkg::CROW_W-1:0] o_corner_row,
    output logic [lesf_pkg::CCOL_W-1:0] o_corner_col
);

    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int SW  = $clog2(MAX_COLS + 1);
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);

    localparam logic [CCW-1:0] COL_LIMIT = CCW'(MAX_COLS);
    localparam logic [RCW-1:0] ROW_LIMIT = RCW'(MAX_ROWS);

    // configuration register
    logic [lesf_pkg::BYTE_W-1:0] r_obstacle;

    // position tracking at the accept stage
    logic [RCW-1:0] r_row_cnt;
    logic [CCW-1:0] r_col_cnt;
    logic [CCW-1:0] r_prior_len;
    logic [CCW-1:0] col_inc;

    // stage 1: line buffer data arrives, size computed
    logic           r_s1_valid;
    logic           r_s1_take;
    logic           r_s1_up_ok;
    logic           r_s1_blocked;
    logic           r_s1_line_end;
    logic           r_s1_map_end;
    logic [CIW-1:0] r_s1_col;
    logic [RIW-1:0] r_s1_row;
    logic [SW-1:0]  r_left;
    logic [SW-1:0]  r_diag;

    // stage 2: best square compare
    lesf_pkg::t_cell_ctl r_s2_ctl;
    logic [SW-1:0]       r_s2_size;
    logic [RIW-1:0]      r_s2_row;
    logic [CIW-1:0]      r_s2_col;

    // output register
    logic                r_out_valid;
    logic [SW-1:0]       r_out_side;
    logic [RIW-1:0]      r_out_row;
    logic [CIW-1:0]      r_out_col;

    logic           en;
    logic           in_beat;
    logic           take_a;
    logic           up_ok_a;
    logic [CIW-1:0] rd_addr;
    logic [SW-1:0]  rd_data;
    logic [SW-1:0]  up;
    logic [SW-1:0]  m_ul;
    logic [SW-1:0]  m_all;
    logic [SW-1:0]  size;
    logic           wr_en;

    logic           load;
    logic [SW-1:0]  res_side;
    logic [RIW-1:0] res_row;
    logic [CIW-1:0] res_col;

    // the whole pipeline freezes only when a map result is stuck behind a full
    // output register
    assign en = !(r_s2_ctl.valid && r_s2_ctl.map_end && r_out_valid && !i_out_ready);

    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign in_beat     = i_in_valid && en;

    // accept stage decode
    assign take_a  = (r_row_cnt < ROW_LIMIT) && (r_col_cnt < COL_LIMIT);
    assign up_ok_a = (r_row_cnt != '0) && (r_col_cnt < r_prior_len);
    assign rd_addr = r_col_cnt[CIW-1:0];
    assign col_inc = (r_col_cnt < COL_LIMIT) ? (r_col_cnt + CCW'(1)) : r_col_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obstacle <= lesf_pkg::OBSTACLE_RESET;
        end else if (i_cfg_valid) begin
            r_obstacle <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt   <= '0;
            r_col_cnt   <= '0;
            r_prior_len <= '0;
        end else if (in_beat) begin
            if (i_map_end) begin
                // new map starts with the next cell
                r_row_cnt   <= '0;
                r_col_cnt   <= '0;
                r_prior_len <= '0;
            end else if (i_row_end) begin
                if (r_row_cnt < ROW_LIMIT) begin
                    r_prior_len <= col_inc;
                    r_row_cnt   <= r_row_cnt + RCW'(1);
                end
                r_col_cnt <= '0;
            end else begin
                r_col_cnt <= col_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_take     <= take_a;
            r_s1_up_ok    <= up_ok_a;
            r_s1_blocked  <= (i_cell_byte == r_obstacle);
            r_s1_line_end <= i_row_end || i_map_end;
            r_s1_map_end  <= i_map_end;
            r_s1_col      <= rd_addr;
            r_s1_row      <= r_row_cnt[RIW-1:0];
        end
    end

    lesf_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_col),
        .i_wr_data (size),
        .o_rd_data (rd_data)
    );

    // min of above, left and diagonal, plus one
    assign up    = r_s1_up_ok ? rd_data : '0;
    assign m_ul  = (up < r_left) ? up : r_left;
    assign m_all = (m_ul < r_diag) ? m_ul : r_diag;
    assign size  = r_s1_blocked ? '0 : SW'({1'b0, m_all} + 1'b1);
    assign wr_en = en && r_s1_valid && r_s1_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_diag <= '0;
        end else if (en && r_s1_valid) begin
            if (r_s1_line_end) begin
                r_left <= '0;
                r_diag <= '0;
            end else if (r_s1_take) begin
                r_left <= size;
                r_diag <= up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (en) begin
            r_s2_ctl.valid   <= r_s1_valid;
            r_s2_ctl.take    <= r_s1_take;
            r_s2_ctl.map_end <= r_s1_map_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_size <= size;
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
        end
    end

    lesf_best_track #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_best_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_s2_ctl),
        .i_size  (r_s2_size),
        .i_row   (r_s2_row),
        .i_col   (r_s2_col),
        .o_load  (load),
        .o_side  (res_side),
        .o_row   (res_row),
        .o_col   (res_col)
    );

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_side <= res_side;
            r_out_row  <= res_row;
            r_out_col  <= res_col;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_largest_side = lesf_pkg::SIDE_W'(r_out_side);
    assign o_corner_row   = lesf_pkg::CROW_W'(r_out_row);
    assign o_corner_col   = lesf_pkg::CCOL_W'(r_out_col);

endmodule

/* hdl/lesf_line_buf.sv */
module lesf_line_buf #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int SW  = $clog2(MAX_COLS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [CIW-1:0]       i_rd_addr,
    input  logic                 i_wr_en,
    input  logic [CIW-1:0]       i_wr_addr,
    input  logic [SW-1:0]        i_wr_data,
    output logic [SW-1:0]        o_rd_data
);

    logic [SW-1:0] r_mem [MAX_COLS];
    logic [SW-1:0] r_rd_data;
    logic [SW-1:0] r_fwd_data;
    logic          r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read held while the pipeline stalls; a write to the same entry in the
    // read cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

/* hdl/lesf_best_track.sv */
module lesf_best_track #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int SW  = $clog2(MAX_COLS + 1),
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  lesf_pkg::t_cell_ctl  i_ctl,
    input  logic [SW-1:0]        i_size,
    input  logic [RIW-1:0]       i_row,
    input  logic [CIW-1:0]       i_col,
    output logic                 o_load,
    output logic [SW-1:0]        o_side,
    output logic [RIW-1:0]       o_row,
    output logic [CIW-1:0]       o_col
);

    localparam int TW  = ((RIW > SW) ? RIW : SW) + 1;
    localparam int UW  = ((CIW > SW) ? CIW : SW) + 1;

    logic [SW-1:0]  r_best_side;
    logic [RIW-1:0] r_best_row;
    logic [CIW-1:0] r_best_col;

    logic [TW-1:0]  tr_wide;
    logic [UW-1:0]  tc_wide;
    logic [RIW-1:0] tr;
    logic [CIW-1:0] tc;
    logic           better;

    // top-left corner of the square anchored at this cell
    assign tr_wide = TW'(i_row) + TW'(1) - TW'(i_size);
    assign tc_wide = UW'(i_col) + UW'(1) - UW'(i_size);
    assign tr      = tr_wide[RIW-1:0];
    assign tc      = tc_wide[CIW-1:0];

    always_comb begin
        better = 1'b0;
        if (i_ctl.valid && i_ctl.take && (i_size != '0)) begin
            if (i_size > r_best_side) begin
                better = 1'b1;
            end else if (i_size == r_best_side) begin
                better = (tr < r_best_row) || ((tr == r_best_row) && (tc < r_best_col));
            end
        end
    end

    assign o_side = better ? i_size : r_best_side;
    assign o_row  = better ? tr     : r_best_row;
    assign o_col  = better ? tc     : r_best_col;
    assign o_load = i_en && i_ctl.valid && i_ctl.map_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_side <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (i_en && i_ctl.valid) begin
            if (i_ctl.map_end) begin
                r_best_side <= '0;
                r_best_row  <= '0;
                r_best_col  <= '0;
            end else if (better) begin
                r_best_side <= i_size;
                r_best_row  <= tr;
                r_best_col  <= tc;
            end
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int MAX_COLS    = lesf_pkg::MAX_COLS_DEF;
    localparam int MAX_ROWS    = lesf_pkg::MAX_ROWS_DEF;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off to back up the block
    localparam int SETTLE      = 8;     // pipeline settle time after a drain

    // one cell beat as offered on the input channel
    typedef struct packed {
        logic [lesf_pkg::BYTE_W-1:0] cell_byte;
        logic                        row_end;
        logic                        map_end;
    } t_map_beat;

    // one map result: side and top-left corner of the winning square
    typedef struct packed {
        logic [lesf_pkg::SIDE_W-1:0] side;
        logic [lesf_pkg::CROW_W-1:0] row;
        logic [lesf_pkg::CCOL_W-1:0] col;
    } t_square;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_cfg_valid    = 1'b0;
    logic                        o_cfg_ready;
    logic [lesf_pkg::BYTE_W-1:0] i_cfg_data     = '0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_ready;
    logic [lesf_pkg::BYTE_W-1:0] i_cell_byte    = '0;
    logic                        i_row_end      = 1'b0;
    logic                        i_map_end      = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready    = 1'b0;
    logic [lesf_pkg::SIDE_W-1:0] o_largest_side;
    logic [lesf_pkg::CROW_W-1:0] o_corner_row;
    logic [lesf_pkg::CCOL_W-1:0] o_corner_col;

    largest_empty_square_finder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cell_byte    (i_cell_byte),
        .i_row_end      (i_row_end),
        .i_map_end      (i_map_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_largest_side (o_largest_side),
        .o_corner_row   (o_corner_row),
        .o_corner_col   (o_corner_col)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // stimulus store and traffic shaping knobs
    // ------------------------------------------------------------------
    t_map_beat pending_cells[$];      // beats waiting for the driver
    t_square   expected_squares[$];   // predicted results, oldest first
    int        send_idle_pct  = 0;    // chance in 100 the sender skips a cycle
    int        recv_stall_pct = 0;    // chance in 100 the receiver drops ready
    bit        hold_request   = 1'b0; // asks the hold process for a long stall
    logic      rx_hold        = 1'b0;

    int mismatches     = 0;
    int cells_taken    = 0;
    int results_seen   = 0;
    int cells_queued   = 0;
    int obstacle_sets  = 1;

    // ------------------------------------------------------------------
    // predictor state: one line of square sizes plus the running best
    // ------------------------------------------------------------------
    logic [lesf_pkg::BYTE_W-1:0] blocked_byte = lesf_pkg::OBSTACLE_RESET;
    logic [lesf_pkg::SIDE_W-1:0] size_line[MAX_COLS];
    int                          line_len  = 0;  // cells the previous row wrote
    logic [lesf_pkg::SIDE_W-1:0] left_sz   = '0;
    logic [lesf_pkg::SIDE_W-1:0] diag_sz   = '0;
    int                          map_row   = 0;
    int                          map_col   = 0;
    int                          best_side = 0;
    int                          best_row  = 0;
    int                          best_col  = 0;

    // square-size update for one accepted cell; queues a result on map_end
    task automatic step_square_map(input t_map_beat beat);
        logic [lesf_pkg::SIDE_W-1:0] above;
        logic [lesf_pkg::SIDE_W-1:0] low;
        logic [lesf_pkg::SIDE_W-1:0] sz;
        int                          top_r;
        int                          top_c;
        t_square                     res;
        if (map_row < MAX_ROWS && map_col < MAX_COLS) begin
            // ragged rows: nothing above a column the previous row never reached
            above = (map_row > 0 && map_col < line_len) ? size_line[map_col] : '0;
            sz    = '0;
            if (beat.cell_byte != blocked_byte) begin
                low = (above < left_sz) ? above : left_sz;
                low = (low < diag_sz) ? low : diag_sz;
                sz  = low + 1'b1;
            end
            diag_sz           = above;
            left_sz           = sz;
            size_line[map_col] = sz;
            if (sz != 0) begin
                top_r = map_row + 1 - int'(sz);
                top_c = map_col + 1 - int'(sz);
                // ties go to the corner first in row-major order
                if (int'(sz) > best_side ||
                    (int'(sz) == best_side &&
                     (top_r < best_row || (top_r == best_row && top_c < best_col)))) begin
                    best_side = int'(sz);
                    best_row  = top_r;
                    best_col  = top_c;
                end
            end
        end
        // counters saturate, marks past the limits still act
        if (map_col < MAX_COLS)
            map_col++;
        if (beat.row_end || beat.map_end) begin
            if (map_row < MAX_ROWS) begin
                line_len = map_col;
                map_row++;
            end
            map_col = 0;
            left_sz = '0;
            diag_sz = '0;
        end
        if (beat.map_end) begin
            res.side = best_side[lesf_pkg::SIDE_W-1:0];
            res.row  = best_row[lesf_pkg::CROW_W-1:0];
            res.col  = best_col[lesf_pkg::CCOL_W-1:0];
            expected_squares.push_back(res);
            line_len  = 0;
            map_row   = 0;
            map_col   = 0;
            best_side = 0;
            best_row  = 0;
            best_col  = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // cell driver: offers queued beats, holds each until taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : cell_driver
        t_map_beat next_beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                step_square_map('{cell_byte: i_cell_byte, row_end: i_row_end,
                                  map_end: i_map_end});
                cells_taken++;
            end
            // free to move on when nothing is offered or the beat just went in
            if (!i_in_valid || o_in_ready) begin
                if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_beat   = pending_cells.pop_front();
                    i_in_valid  <= 1'b1;
                    i_cell_byte <= next_beat.cell_byte;
                    i_row_end   <= next_beat.row_end;
                    i_map_end   <= next_beat.map_end;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string field, input int want, input int got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    // ------------------------------------------------------------------
    // result monitor: checks every taken result beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_square want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_squares.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result with none expected, got side %0d corner %0d,%0d",
                             $time, o_largest_side, o_corner_row, o_corner_col);
                end else begin
                    want = expected_squares.pop_front();
                    if (o_largest_side !== want.side)
                        report_field("largest_side", int'(want.side), int'(o_largest_side));
                    if (o_corner_row !== want.row)
                        report_field("corner_row", int'(want.row), int'(o_corner_row));
                    if (o_corner_col !== want.col)
                        report_field("corner_col", int'(want.col), int'(o_corner_col));
                end
            end
            i_out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing meanwhile
    always begin : receiver_hold
        @(posedge i_clk);
        if (hold_request) begin
            hold_request = 1'b0;
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [lesf_pkg::BYTE_W-1:0] open_byte();
        logic [lesf_pkg::BYTE_W-1:0] b;
        b = lesf_pkg::BYTE_W'($urandom_range(255));
        if (b == blocked_byte)
            b = b ^ 8'h01;
        return b;
    endfunction

    task automatic push_cell(input logic [lesf_pkg::BYTE_W-1:0] byte_val, input logic row_end,
                             input logic map_end);
        pending_cells.push_back('{cell_byte: byte_val, row_end: row_end, map_end: map_end});
        cells_queued++;
    endtask

    // one well-formed map; open_last drops the row mark on the final cell
    task automatic queue_map(input int rows, input int cols, input int block_pct,
                             input bit ragged, input bit open_last);
        int  len;
        bit  last;
        for (int r = 0; r < rows; r++) begin
            len = ragged ? $urandom_range(cols, 1) : cols;
            for (int c = 0; c < len; c++) begin
                last = (r == rows - 1) && (c == len - 1);
                push_cell(($urandom_range(99) < block_pct) ? blocked_byte : open_byte(),
                          (c == len - 1) && !(last && open_last), last);
            end
        end
    endtask

    // mostly real maps with random content, some noise with random marks
    task automatic queue_random(input int target);
        int start_count;
        start_count = cells_queued;
        while (cells_queued - start_count < target) begin
            case ($urandom_range(9))
                0: begin
                    // noise: loose cells, marks at random, occasional early map end
                    repeat ($urandom_range(4, 1))
                        push_cell(lesf_pkg::BYTE_W'($urandom_range(255)),
                                  1'($urandom_range(1)),
                                  $urandom_range(7) == 0);
                end
                1: queue_map($urandom_range(14, 6), $urandom_range(16, 6),
                             $urandom_range(8), $urandom_range(3) == 0,
                             $urandom_range(2) == 0);
                default: queue_map($urandom_range(6, 1), $urandom_range(8, 1),
                                   $urandom_range(60), $urandom_range(3) == 0,
                                   $urandom_range(2) == 0);
            endcase
        end
        // close whatever the noise left open so the block ends idle
        queue_map(1, 1, 50, 1'b0, 1'b0);
    endtask

    // every beat taken, every result checked, then let the pipeline settle
    task automatic drain();
        do
            @(posedge i_clk);
        while (pending_cells.size() != 0 || i_in_valid || expected_squares.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write, only while the block is idle
    task automatic write_obstacle(input logic [lesf_pkg::BYTE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        blocked_byte = value;
        obstacle_sets++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_traffic(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed maps with the reset obstacle byte
        set_traffic(0, 0);
        push_cell(lesf_pkg::OBSTACLE_RESET, 1'b0, 1'b1); // lone blocked cell: side 0 at 0,0
        push_cell(8'h00, 1'b0, 1'b1);            // lone open cell, map end without row end
        push_cell(8'hFF, 1'b0, 1'b0);            // full 2x2
        push_cell(8'hFF, 1'b1, 1'b0);
        push_cell(8'hFF, 1'b0, 1'b0);
        push_cell(8'hFF, 1'b1, 1'b1);
        push_cell(8'h6E, 1'b1, 1'b0);            // ragged: short row then a longer one
        push_cell(8'h70, 1'b0, 1'b0);
        push_cell(8'h55, 1'b0, 1'b0);
        push_cell(8'hAA, 1'b0, 1'b1);
        push_cell(lesf_pkg::OBSTACLE_RESET, 1'b0, 1'b0); // tie: row-major first corner wins
        push_cell(8'h01, 1'b1, 1'b0);
        push_cell(8'h80, 1'b0, 1'b0);
        push_cell(lesf_pkg::OBSTACLE_RESET, 1'b1, 1'b1);
        drain();

        // receiver holds off while tiny maps keep coming, so the input backs up
        @(negedge i_clk);
        hold_request = 1'b1;
        repeat (40)
            queue_map($urandom_range(2, 1), $urandom_range(2, 1), 30, 1'b0, 1'b0);
        drain();

        // obstacle byte at its low extreme, sender mostly idle
        write_obstacle(8'h00);
        set_traffic(74, 0);
        queue_random(310);
        drain();

        // obstacle byte at its high extreme, receiver mostly stalled
        write_obstacle(8'hFF);
        set_traffic(0, 74);
        queue_random(310);
        drain();

        // random obstacle byte, both sides idling
        write_obstacle(lesf_pkg::BYTE_W'($urandom_range(255)));
        set_traffic(25, 25);
        queue_random(310);
        drain();

        // back to the usual obstacle, full rate, plus maps past the size limits
        write_obstacle(lesf_pkg::OBSTACLE_RESET);
        set_traffic(0, 0);
        queue_random(320);
        // two wide rows: 2x2 square at the last columns, cells past the width ignored
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < MAX_COLS + 6; c++)
                push_cell((c >= MAX_COLS - 2) ? open_byte() : blocked_byte,
                          c == MAX_COLS + 5, (r == 1) && (c == MAX_COLS + 5));
        // one tall column: only the last counted row is open, later rows ignored
        for (int r = 0; r < MAX_ROWS + 4; r++)
            push_cell((r >= MAX_ROWS - 1) ? open_byte() : blocked_byte,
                      1'b1, r == MAX_ROWS + 3);
        drain();

        if (expected_squares.size() != 0) begin
            mismatches++;
            $display("%0t ns: %0d predicted results never arrived", $time,
                     expected_squares.size());
        end

        $display("run covered %0d cells and %0d map results over %0d obstacle settings,",
                 cells_taken, results_seen, obstacle_sets);
        $display("with idle and stalled traffic, a long output hold-off and oversize maps");
        if (mismatches == 0) begin
            $display("largest_empty_square_finder regression: pass");
        end else begin
            $display("largest_empty_square_finder regression: fail");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #2000000;
        $display("largest_empty_square_finder regression: fail");
        $finish;
    end

endmodule
